FILE: rtl/ppu_pkg.sv
`default_nettype none
package ppu_pkg;

  localparam int unsigned PoolSizeDefault = 64;
  localparam int unsigned CountW = 7;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_SPAWN  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_RENDER = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PROBE,
    ST_SPAWN_WR,
    ST_RD,
    ST_TK_GRAV,
    ST_TK_POSX,
    ST_TK_POSY,
    ST_TK_ROT,
    ST_TK_WR,
    ST_RN_DIV,
    ST_RN_LERP,
    ST_RN_EMIT,
    ST_OUT
  } state_e;

  // One particle record
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] color_start;
    logic [31:0] color_end;
    logic [31:0] life;
    logic [31:0] max_life;
    logic [31:0] size_start;
    logic [31:0] size_end;
    logic [31:0] rotation;
    logic [31:0] spin;
    logic [31:0] gravity;
    logic        blend;
  } slot_t;

  // Output record, fields listed from high to low
  typedef struct packed {
    logic              last;
    logic [CountW-1:0] active_count;
    logic              draw_blend;
    logic [31:0]       draw_rotation;
    logic [31:0]       draw_color;
    logic [31:0]       draw_size;
    logic [31:0]       draw_y;
    logic [31:0]       draw_x;
    logic [1:0]        kind;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/ppu_divider.sv
`default_nettype none
// Restoring divider: q = floor((life << 16) / max_life), one quotient bit per cycle.
// Quotient is capped at 65536 here; 17 bits plus saturation is enough.
module ppu_divider (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [31:0] num_i,
  input  wire  [31:0] den_i,
  output logic        done_o,
  output logic [16:0] quot_o
);
  // Quotient above 2^16 saturates; keep 18 bits and flag any bit shifted out above them.
  logic [47:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [17:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        big_q, big_d;
  logic [32:0] trial;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    big_d = big_q;
    trial = '0;
    done_o = 1'b0;
    if (start_i) begin
      num_d = {num_i, 16'd0};
      rem_d = '0;
      quo_d = '0;
      cnt_d = 6'd48;
      busy_d = 1'b1;
      big_d = 1'b0;
    end else if (busy_q) begin
      // shift one numerator bit into the remainder
      trial = {rem_q[31:0], num_q[47]};
      num_d = {num_q[46:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        if (quo_q[17]) big_d = 1'b1;
        quo_d = {quo_q[16:0], 1'b1};
      end else begin
        rem_d = trial;
        if (quo_q[17]) big_d = 1'b1;
        quo_d = {quo_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end else begin
      done_o = 1'b0;
    end
    if (busy_q && cnt_q == 6'd1) done_o = 1'b1;
  end

  // Saturating quotient as seen after the last step
  always_comb begin
    if (big_d || quo_d[17] || quo_d[16:0] > 17'd65536) quot_o = 17'd65536;
    else quot_o = quo_d[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    big_q <= big_d;
  end
endmodule
`default_nettype wire

FILE: rtl/particle_pool_update.sv
`default_nettype none
// Clear resets the pool and acknowledges; spawn probes 1 to POOL_SIZE slots from the hint,
// then writes; tick updates each live slot through one shared multiplier (four products)
// and skips other slots; render makes two passes of POOL_SIZE slots, with a divide and a lerp
// per candidate slot, and can stall on the output. One command at a time:
// s_axis_tready is high only when idle with the output register empty.
// Reset clears all valid bits, the free hint and the live count.
module particle_pool_update #(
  parameter int unsigned POOL_SIZE = ppu_pkg::PoolSizeDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], position[65:2], velocity[129:66], color_start[161:130],
  // color_end[193:162], life_or_dt[224:194], size_start[256:225],
  // size_end[288:257], gravity[320:289], rotation[352:321],
  // rotation_speed[384:353], zero pad to 392
  input  wire  [391:0] s_axis_tdata,
  // blend
  input  wire          s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // draw_x[31:0], draw_y[63:32], draw_size[95:64], draw_color[127:96],
  // draw_rotation[159:128], draw_blend[160], active_count[167:161]
  output logic [167:0] m_axis_tdata,
  // kind
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  localparam int unsigned IdxW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CntW = $clog2(POOL_SIZE + 1);

  ppu_pkg::state_e state_q, state_d;
  ppu_pkg::slot_t  mem [POOL_SIZE];
  ppu_pkg::slot_t  rd_q;
  logic [POOL_SIZE-1:0] act_q, act_d;
  logic [IdxW-1:0] hint_q, hint_d, idx_q, idx_d;
  logic [CntW-1:0] live_q, live_d, cnt_q, cnt_d;
  logic [CntW-1:0] step_q, step_d;
  logic [1:0] cmd_q, cmd_d;
  logic [382:0] in_q;
  logic in_blend_q;
  logic mode_q, mode_d;
  logic drawn_q, drawn_d;
  ppu_pkg::slot_t cur_q, cur_d;
  logic mem_we;
  logic [IdxW-1:0] mem_wa;
  ppu_pkg::slot_t mem_wd;
  ppu_pkg::result_t res_q, res_d;
  ppu_pkg::result_t hold_q, hold_d;
  logic res_v_q, res_v_d;
  logic [16:0] t_q, t_d;
  logic [2:0]  lstep_q, lstep_d;
  logic [31:0] col_q, col_d;
  logic [31:0] sz_q, sz_d;
  logic div_start, div_done;
  logic [16:0] div_quot;
  logic [31:0] dt;

  // shared multiplier: signed 32 x unsigned 32 (dt) / signed 34 x 17 (lerp)
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod;
  logic [31:0] mulq;
  logic signed [32:0] la, lb;

  assign prod = mul_a * mul_b;
  assign mulq = prod[47:16];
  assign dt = {1'b0, in_q[222:192]};

  ppu_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(cur_q.life), .den_i(cur_q.max_life),
    .done_o(div_done), .quot_o(div_quot)
  );

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] i);
    nxt = (32'(i) == POOL_SIZE - 1) ? '0 : i + IdxW'(1);
  endfunction

  // lerp operand select per step: 0 size, 1..4 color R,G,B,A
  always_comb begin
    case (lstep_q)
      3'd0: begin
        la = {cur_q.size_start[31], cur_q.size_start};
        lb = {cur_q.size_end[31], cur_q.size_end};
      end
      3'd1: begin la = 33'(cur_q.color_start[31:24]); lb = 33'(cur_q.color_end[31:24]); end
      3'd2: begin la = 33'(cur_q.color_start[23:16]); lb = 33'(cur_q.color_end[23:16]); end
      3'd3: begin la = 33'(cur_q.color_start[15:8]);  lb = 33'(cur_q.color_end[15:8]); end
      default: begin la = 33'(cur_q.color_start[7:0]); lb = 33'(cur_q.color_end[7:0]); end
    endcase
  end

  always_comb begin
    logic [31:0] lv;
    logic signed [33:0] diff;
    state_d = state_q; act_d = act_q; hint_d = hint_q; idx_d = idx_q;
    live_d = live_q; cnt_d = cnt_q; step_d = step_q; cmd_d = cmd_q;
    mode_d = mode_q; drawn_d = drawn_q; cur_d = cur_q; res_d = res_q;
    hold_d = hold_q;
    res_v_d = res_v_q; t_d = t_q; lstep_d = lstep_q; col_d = col_q; sz_d = sz_q;
    mem_we = 1'b0; mem_wa = idx_q; mem_wd = cur_q;
    div_start = 1'b0; mul_a = '0; mul_b = '0; lv = '0;
    diff = {lb[32], lb} - {la[32], la};
    s_axis_tready = (state_q == ppu_pkg::ST_IDLE) && !res_v_q;
    if (res_v_q && m_axis_tready) res_v_d = 1'b0;

    case (state_q)
      ppu_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_d = s_axis_tdata[1:0];
          idx_d = '0;
          step_d = '0;
          case (ppu_pkg::cmd_e'(s_axis_tdata[1:0]))
            ppu_pkg::CMD_CLEAR:  state_d = ppu_pkg::ST_CLEAR;
            ppu_pkg::CMD_SPAWN: begin idx_d = hint_q; state_d = ppu_pkg::ST_PROBE; end
            ppu_pkg::CMD_TICK: begin cnt_d = '0; state_d = ppu_pkg::ST_RD; end
            default: begin mode_d = 1'b0; drawn_d = 1'b0; state_d = ppu_pkg::ST_RD; end
          endcase
        end
      end
      ppu_pkg::ST_CLEAR: begin
        act_d = '0; live_d = '0; hint_d = '0;
        res_d = '0; res_d.kind = ppu_pkg::KIND_ACK; res_d.last = 1'b1;
        state_d = ppu_pkg::ST_OUT;
      end
      // one slot checked per cycle from the hint
      ppu_pkg::ST_PROBE: begin
        if (!act_q[idx_q]) begin
          live_d = live_q + CntW'(1);
          state_d = ppu_pkg::ST_SPAWN_WR;
        end else if (32'(step_q) == POOL_SIZE - 1) begin
          idx_d = hint_q;
          state_d = ppu_pkg::ST_SPAWN_WR;
        end else begin
          idx_d = nxt(idx_q);
          step_d = step_q + CntW'(1);
        end
      end
      ppu_pkg::ST_SPAWN_WR: begin
        mem_we = 1'b1;
        mem_wd.pos_x = in_q[63:32];   mem_wd.pos_y = in_q[31:0];
        mem_wd.vel_x = in_q[127:96];  mem_wd.vel_y = in_q[95:64];
        mem_wd.color_start = in_q[159:128]; mem_wd.color_end = in_q[191:160];
        mem_wd.life = dt; mem_wd.max_life = dt;
        mem_wd.size_start = in_q[254:223]; mem_wd.size_end = in_q[286:255];
        mem_wd.gravity = in_q[318:287]; mem_wd.rotation = in_q[350:319];
        mem_wd.spin = in_q[382:351]; mem_wd.blend = in_blend_q;
        act_d[idx_q] = 1'b1;
        hint_d = nxt(idx_q);
        res_d = '0; res_d.kind = ppu_pkg::KIND_ACK; res_d.last = 1'b1;
        res_d.active_count = ppu_pkg::CountW'(live_q);
        state_d = ppu_pkg::ST_OUT;
      end
      // slot fetch for tick and render; rd_q holds the slot at idx_q
      ppu_pkg::ST_RD: begin
        cur_d = rd_q;
        if (cmd_q == ppu_pkg::CMD_TICK) begin
          if (act_q[idx_q]) begin
            if (dt >= rd_q.life) begin
              act_d[idx_q] = 1'b0;
              state_d = ppu_pkg::ST_TK_WR;
            end else state_d = ppu_pkg::ST_TK_GRAV;
          end else state_d = ppu_pkg::ST_TK_WR;
        end else begin
          if (act_q[idx_q] && rd_q.blend == mode_q && live_q != '0) begin
            if (rd_q.max_life == '0) begin
              t_d = 17'd65536; lstep_d = '0; state_d = ppu_pkg::ST_RN_LERP;
            end else state_d = ppu_pkg::ST_RN_DIV;
          end else state_d = ppu_pkg::ST_RN_EMIT;
        end
      end
      ppu_pkg::ST_TK_GRAV: begin
        mul_a = {{2{cur_q.gravity[31]}}, cur_q.gravity}; mul_b = {1'b0, dt};
        cur_d.vel_y = cur_q.vel_y + mulq;
        cur_d.life = cur_q.life - dt;
        state_d = ppu_pkg::ST_TK_POSX;
      end
      ppu_pkg::ST_TK_POSX: begin
        mul_a = {{2{cur_q.vel_x[31]}}, cur_q.vel_x}; mul_b = {1'b0, dt};
        cur_d.pos_x = cur_q.pos_x + mulq;
        state_d = ppu_pkg::ST_TK_POSY;
      end
      ppu_pkg::ST_TK_POSY: begin
        mul_a = {{2{cur_q.vel_y[31]}}, cur_q.vel_y}; mul_b = {1'b0, dt};
        cur_d.pos_y = cur_q.pos_y + mulq;
        state_d = ppu_pkg::ST_TK_ROT;
      end
      ppu_pkg::ST_TK_ROT: begin
        mul_a = {{2{cur_q.spin[31]}}, cur_q.spin}; mul_b = {1'b0, dt};
        cur_d.rotation = cur_q.rotation + mulq;
        mem_we = 1'b1; mem_wd = cur_d;
        cnt_d = cnt_q + CntW'(1);
        state_d = ppu_pkg::ST_TK_WR;
      end
      // advance slot; finish tick at the end of the pool
      ppu_pkg::ST_TK_WR: begin
        if (32'(idx_q) == POOL_SIZE - 1) begin
          live_d = cnt_q;
          res_d = '0; res_d.kind = ppu_pkg::KIND_ACK; res_d.last = 1'b1;
          res_d.active_count = ppu_pkg::CountW'(cnt_q);
          state_d = ppu_pkg::ST_OUT;
        end else begin
          idx_d = nxt(idx_q);
          state_d = ppu_pkg::ST_RD;
        end
      end
      ppu_pkg::ST_RN_DIV: begin
        if (step_q == '0) begin
          div_start = 1'b1; step_d = CntW'(1);
        end else if (div_done) begin
          t_d = 17'd65536 - div_quot; step_d = '0; lstep_d = '0;
          state_d = ppu_pkg::ST_RN_LERP;
        end
      end
      // size, then four color channels if the size is at least 32768, through the multiplier;
      // a finished draw waits while the previous one is held and the output register is busy
      ppu_pkg::ST_RN_LERP: begin
        if (lstep_q != 3'd4 || !drawn_q || !res_v_q || m_axis_tready) begin
          mul_a = diff; mul_b = {16'd0, t_q};
          lv = 32'(la + 33'(prod >>> 16));
          if (lstep_q == 3'd0) begin
            sz_d = lv;
            if ($signed(lv) < 32'sd32768) state_d = ppu_pkg::ST_RN_EMIT;
            else lstep_d = 3'd1;
          end else begin
            case (lstep_q)
              3'd1: col_d[31:24] = lv[7:0];
              3'd2: col_d[23:16] = lv[7:0];
              3'd3: col_d[15:8]  = lv[7:0];
              default: col_d[7:0] = lv[7:0];
            endcase
            if (lstep_q == 3'd4) begin
              // release the held draw, hold the new one
              if (drawn_q) begin
                res_d = hold_q; res_v_d = 1'b1;
              end
              hold_d = '0; hold_d.kind = ppu_pkg::KIND_DRAW;
              hold_d.draw_x = cur_q.pos_x; hold_d.draw_y = cur_q.pos_y;
              hold_d.draw_size = sz_q; hold_d.draw_color = {col_q[31:8], lv[7:0]};
              hold_d.draw_rotation = cur_q.rotation; hold_d.draw_blend = mode_q;
              hold_d.active_count = ppu_pkg::CountW'(live_q);
              drawn_d = 1'b1;
              state_d = ppu_pkg::ST_RN_EMIT;
            end else lstep_d = lstep_q + 3'd1;
          end
        end
      end
      // advance over slots and passes; last flag set on the final record only
      ppu_pkg::ST_RN_EMIT: begin
        if (32'(idx_q) == POOL_SIZE - 1 && mode_q == 1'b0) begin
          mode_d = 1'b1; idx_d = '0; state_d = ppu_pkg::ST_RD;
        end else if (32'(idx_q) == POOL_SIZE - 1) begin
          if (!res_v_q || m_axis_tready) begin
            if (drawn_q) begin
              // final record was held back; send it now as last
              res_d = hold_q; res_d.last = 1'b1; res_v_d = 1'b1;
            end else begin
              res_d = '0; res_d.kind = ppu_pkg::KIND_EMPTY; res_d.last = 1'b1;
              res_d.active_count = ppu_pkg::CountW'(live_q); res_v_d = 1'b1;
            end
            state_d = ppu_pkg::ST_IDLE;
          end else res_v_d = res_v_q;
        end else begin
          idx_d = nxt(idx_q); state_d = ppu_pkg::ST_RD;
        end
      end
      ppu_pkg::ST_OUT: begin
        res_v_d = 1'b1; state_d = ppu_pkg::ST_IDLE;
      end
      default: state_d = ppu_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    m_axis_tvalid = res_v_q;
    m_axis_tdata = {res_q.active_count, res_q.draw_blend, res_q.draw_rotation,
                    res_q.draw_color, res_q.draw_size, res_q.draw_y, res_q.draw_x};
    m_axis_tuser = res_q.kind;
    m_axis_tlast = res_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppu_pkg::ST_IDLE;
      act_q <= '0; hint_q <= '0; live_q <= '0; idx_q <= '0; cnt_q <= '0;
      step_q <= '0; cmd_q <= '0; mode_q <= 1'b0; drawn_q <= 1'b0;
      res_v_q <= 1'b0; lstep_q <= '0;
    end else begin
      state_q <= state_d; act_q <= act_d; hint_q <= hint_d; live_q <= live_d;
      idx_q <= idx_d; cnt_q <= cnt_d; step_q <= step_d; cmd_q <= cmd_d;
      mode_q <= mode_d; drawn_q <= drawn_d; res_v_q <= res_v_d; lstep_q <= lstep_d;
    end
  end

  // payload and pool memory, read at the next slot address
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; res_q <= res_d; hold_q <= hold_d;
    t_q <= t_d; col_q <= col_d; sz_q <= sz_d;
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= s_axis_tdata[384:2];
      in_blend_q <= s_axis_tuser;
    end
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[idx_d];
  end
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 64;

  // One command as it enters the pool
  typedef struct {
    ppu_pkg::cmd_e cmd;
    logic [63:0] pos;
    logic [63:0] vel;
    logic [31:0] col_a;
    logic [31:0] col_b;
    logic [30:0] life;
    logic [31:0] size_a;
    logic [31:0] size_b;
    logic [31:0] grav;
    logic [31:0] rot;
    logic [31:0] spin;
    logic        blend;
  } cmd_item_t;

  // One result record
  typedef struct packed {
    ppu_pkg::kind_e kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] size;
    logic [31:0] color;
    logic [31:0] rot;
    logic        blend;
    logic [6:0]  count;
    logic        last;
  } draw_rec_t;

  // Directed row: a typed expectation where it is obvious
  typedef struct {
    cmd_item_t      item;
    bit             typed;
    ppu_pkg::kind_e kind;
    logic [6:0]     count;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [391:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  particle_pool_update DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow pool
  bit          p_active [Slots];
  logic [31:0] p_px [Slots], p_py [Slots], p_vx [Slots], p_vy [Slots];
  logic [31:0] p_ca [Slots], p_cb [Slots], p_life [Slots], p_maxl [Slots];
  logic [31:0] p_sa [Slots], p_sb [Slots], p_rot [Slots], p_spin [Slots];
  logic [31:0] p_grav [Slots];
  logic        p_blend [Slots];
  int          hint;
  int          live;

  draw_rec_t   pending_draws [$];
  int          errors;
  int          n_sent;
  int          n_draws;
  int          n_empty;
  int          n_full_spawn;

  // Signed Q16.16 times unsigned step, floored, wrapped
  function automatic logic [31:0] scale_step(logic [31:0] s, logic [30:0] step);
    longint p;
    p = longint'(signed'(s)) * longint'({1'b0, step});
    return 32'(p >>> 16);
  endfunction

  function automatic longint mix(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic draw_rec_t ack_rec(ppu_pkg::kind_e k);
    draw_rec_t r;
    r = '{kind: k, x: 0, y: 0, size: 0, color: 0, rot: 0, blend: 0,
          count: 7'(live), last: 1'b1};
    return r;
  endfunction

  // Advance the shadow pool by one command and queue what it yields
  task automatic predict_pool(input cmd_item_t it, input bit typed,
                              input ppu_pkg::kind_e tk, input logic [6:0] tc);
    draw_rec_t r;
    int        idx;
    int        first;
    bit        found;
    longint    t, sz, q;
    logic [31:0] col;
    first = pending_draws.size();
    case (it.cmd)
      ppu_pkg::CMD_CLEAR: begin
        foreach (p_active[i]) p_active[i] = 0;
        live = 0;
        hint = 0;
        pending_draws.push_back(ack_rec(ppu_pkg::KIND_ACK));
      end
      ppu_pkg::CMD_SPAWN: begin
        found = 0;
        idx = hint;
        for (int k = 0; k < Slots; k++) begin
          if (!found && !p_active[(hint + k) % Slots]) begin
            idx = (hint + k) % Slots;
            found = 1;
          end
        end
        if (found) live++;
        else n_full_spawn++;
        p_px[idx] = it.pos[63:32];
        p_py[idx] = it.pos[31:0];
        p_vx[idx] = it.vel[63:32];
        p_vy[idx] = it.vel[31:0];
        p_ca[idx] = it.col_a;
        p_cb[idx] = it.col_b;
        p_life[idx] = {1'b0, it.life};
        p_maxl[idx] = {1'b0, it.life};
        p_sa[idx] = it.size_a;
        p_sb[idx] = it.size_b;
        p_grav[idx] = it.grav;
        p_blend[idx] = it.blend;
        p_rot[idx] = it.rot;
        p_spin[idx] = it.spin;
        p_active[idx] = 1;
        hint = (idx + 1) % Slots;
        pending_draws.push_back(ack_rec(ppu_pkg::KIND_ACK));
      end
      ppu_pkg::CMD_TICK: begin
        live = 0;
        for (int i = 0; i < Slots; i++) begin
          if (p_active[i]) begin
            if ({1'b0, it.life} >= p_life[i]) begin
              p_active[i] = 0;
            end else begin
              p_life[i] = p_life[i] - {1'b0, it.life};
              p_vy[i] = p_vy[i] + scale_step(p_grav[i], it.life);
              p_px[i] = p_px[i] + scale_step(p_vx[i], it.life);
              p_py[i] = p_py[i] + scale_step(p_vy[i], it.life);
              p_rot[i] = p_rot[i] + scale_step(p_spin[i], it.life);
              live++;
            end
          end
        end
        pending_draws.push_back(ack_rec(ppu_pkg::KIND_ACK));
      end
      default: begin
        // normal blend first, then additive
        if (live != 0) begin
          for (int m = 0; m < 2; m++) begin
            for (int i = 0; i < Slots; i++) begin
              if (p_active[i] && p_blend[i] == m[0]) begin
                if (p_maxl[i] == 0) begin
                  t = 65536;
                end else begin
                  q = (longint'(p_life[i]) << 16) / longint'(p_maxl[i]);
                  if (q > 65536) q = 65536;
                  t = 65536 - q;
                end
                sz = mix(longint'(signed'(p_sa[i])), longint'(signed'(p_sb[i])), t);
                if (sz >= 32768) begin
                  for (int c = 0; c < 4; c++) begin
                    col[c*8 +: 8] = 8'(mix(longint'(p_ca[i][c*8 +: 8]),
                                           longint'(p_cb[i][c*8 +: 8]), t));
                  end
                  r = '{kind: ppu_pkg::KIND_DRAW, x: p_px[i], y: p_py[i], size: 32'(sz),
                        color: col, rot: p_rot[i], blend: m[0],
                        count: 7'(live), last: 1'b0};
                  pending_draws.push_back(r);
                  n_draws++;
                end
              end
            end
          end
        end
        if (pending_draws.size() == first) begin
          pending_draws.push_back(ack_rec(ppu_pkg::KIND_EMPTY));
          n_empty++;
        end else begin
          pending_draws[pending_draws.size() - 1].last = 1'b1;
        end
      end
    endcase
    // obvious expectations replace the predicted one
    if (typed) begin
      r = ack_rec(tk);
      r.count = tc;
      if (pending_draws[first] != r) begin
        $display("%0t: typed row exp kind %0d count %0d, shadow kind %0d count %0d",
                 $time, tk, tc, pending_draws[first].kind, pending_draws[first].count);
        errors++;
      end
      pending_draws[first] = r;
    end
  endtask

  function automatic cmd_item_t make_cmd(ppu_pkg::cmd_e c, logic [30:0] life_dt);
    cmd_item_t it;
    it.cmd = c;
    it.pos = {$urandom, $urandom};
    it.vel = {$urandom, $urandom};
    it.col_a = $urandom;
    it.col_b = $urandom;
    it.life = life_dt;
    it.size_a = $urandom;
    it.size_b = $urandom;
    it.grav = $urandom;
    it.rot = $urandom;
    it.spin = $urandom;
    it.blend = $urandom_range(0, 1);
    return it;
  endfunction

  // Spawn that usually stays visible for a while
  function automatic cmd_item_t make_spawn();
    cmd_item_t it;
    it = make_cmd(ppu_pkg::CMD_SPAWN, 31'($urandom_range(1 << 16, 24 << 16)));
    case ($urandom_range(0, 7))
      0: it.life = 31'($urandom);
      1: it.life = 31'($urandom_range(0, 3));
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) begin
      it.size_a = $urandom_range(1 << 15, 16 << 16);
      it.size_b = $urandom_range(0, 16 << 16);
    end
    return it;
  endfunction

  // Send one command, waiting for the transfer
  task automatic send_cmd(input cmd_item_t it, input bit typed, input ppu_pkg::kind_e tk,
                          input logic [6:0] tc);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= 392'({it.spin, it.rot, it.grav, it.size_b, it.size_a, it.life,
                          it.col_b, it.col_a, it.vel, it.pos, it.cmd});
    s_axis_tuser <= it.blend;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pool(it, typed, tk, tc);
    n_sent++;
  endtask

  int burst_left = 0;

  // Bursts of back-to-back commands with random gaps between them
  task automatic pace_then_send(input cmd_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    send_cmd(it, 1'b0, ppu_pkg::KIND_ACK, 7'd0);
  endtask

  // Receiver stall pattern: phases of full speed, random and periodic stalls
  int rx_cyc = 0;
  always @(posedge clk_i) begin
    draw_rec_t want;
    draw_rec_t got;
    rx_cyc <= rx_cyc + 1;
    case ((rx_cyc / 300) % 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= ((rx_cyc % 7) < 3);
    endcase
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: ppu_pkg::kind_e'(m_axis_tuser), x: m_axis_tdata[31:0],
              y: m_axis_tdata[63:32], size: m_axis_tdata[95:64],
              color: m_axis_tdata[127:96], rot: m_axis_tdata[159:128],
              blend: m_axis_tdata[160], count: m_axis_tdata[167:161],
              last: m_axis_tlast};
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result transfer, kind %0d", $time, got.kind);
        errors++;
      end else begin
        want = pending_draws.pop_front();
        if (got.kind != want.kind) begin
          $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind); errors++;
        end
        if (got.x != want.x) begin
          $display("%0t: draw_x exp %h got %h", $time, want.x, got.x); errors++;
        end
        if (got.y != want.y) begin
          $display("%0t: draw_y exp %h got %h", $time, want.y, got.y); errors++;
        end
        if (got.size != want.size) begin
          $display("%0t: draw_size exp %h got %h", $time, want.size, got.size); errors++;
        end
        if (got.color != want.color) begin
          $display("%0t: draw_color exp %h got %h", $time, want.color, got.color);
          errors++;
        end
        if (got.rot != want.rot) begin
          $display("%0t: draw_rotation exp %h got %h", $time, want.rot, got.rot);
          errors++;
        end
        if (got.blend != want.blend) begin
          $display("%0t: draw_blend exp %0d got %0d", $time, want.blend, got.blend);
          errors++;
        end
        if (got.count != want.count) begin
          $display("%0t: active_count exp %0d got %0d", $time, want.count, got.count);
          errors++;
        end
        if (got.last != want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, got.last); errors++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #60ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus
  initial begin
    dir_row_t  rows [$];
    dir_row_t  row;
    cmd_item_t it;
    int        pick;

    foreach (p_active[i]) p_active[i] = 0;
    hint = 0;
    live = 0;
    errors = 0;
    n_sent = 0;
    n_draws = 0;
    n_empty = 0;
    n_full_spawn = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // render and tick on an empty pool, then clear
    rows.push_back('{make_cmd(ppu_pkg::CMD_RENDER, 0), 1, ppu_pkg::KIND_EMPTY, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_TICK, 31'h7FFF_FFFF), 1, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_CLEAR, 0), 1, ppu_pkg::KIND_ACK, 0});
    // spawn with every field at its top or bottom value
    it = make_cmd(ppu_pkg::CMD_SPAWN, 31'h7FFF_FFFF);
    it.pos = '1; it.vel = '1; it.col_a = '1; it.col_b = '0;
    it.size_a = 32'h7FFF_FFFF; it.size_b = 32'h8000_0000;
    it.grav = 32'h7FFF_FFFF; it.rot = 32'h8000_0000; it.spin = 32'h7FFF_FFFF;
    it.blend = 1'b1;
    rows.push_back('{it, 1, ppu_pkg::KIND_ACK, 1});
    // all-zero spawn: zero lifetime and zero size
    it = '{cmd: ppu_pkg::CMD_SPAWN, blend: 1'b0, default: '0};
    rows.push_back('{it, 1, ppu_pkg::KIND_ACK, 2});
    // zero lifetime draws at the end size
    it = make_cmd(ppu_pkg::CMD_SPAWN, 0);
    it.size_a = 0; it.size_b = 32'h0001_0000; it.blend = 1'b0;
    rows.push_back('{it, 1, ppu_pkg::KIND_ACK, 3});
    // just below and exactly at the half-unit size threshold
    it = make_cmd(ppu_pkg::CMD_SPAWN, 31'h0001_0000);
    it.size_a = 32'h0000_7FFF; it.size_b = 32'h0000_7FFF;
    rows.push_back('{it, 1, ppu_pkg::KIND_ACK, 4});
    it = make_cmd(ppu_pkg::CMD_SPAWN, 31'h0001_0000);
    it.size_a = 32'h0000_8000; it.size_b = 32'h0000_8000;
    rows.push_back('{it, 1, ppu_pkg::KIND_ACK, 5});
    rows.push_back('{make_cmd(ppu_pkg::CMD_RENDER, 0), 0, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_TICK, 0), 0, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_TICK, 1), 0, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_RENDER, 0), 0, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_TICK, 31'h0000_8000), 0, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_RENDER, 0), 0, ppu_pkg::KIND_ACK, 0});
    // a huge step kills everything
    rows.push_back('{make_cmd(ppu_pkg::CMD_TICK, 31'h7FFF_FFFF), 1, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_RENDER, 0), 1, ppu_pkg::KIND_EMPTY, 0});
    it = make_spawn();
    it.grav = 32'hFFF0_0000;
    rows.push_back('{it, 0, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_RENDER, 0), 0, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_CLEAR, 0), 1, ppu_pkg::KIND_ACK, 0});
    rows.push_back('{make_cmd(ppu_pkg::CMD_RENDER, 0), 1, ppu_pkg::KIND_EMPTY, 0});

    foreach (rows[i]) begin
      row = rows[i];
      send_cmd(row.item, row.typed, row.kind, row.count);
    end
    s_axis_tvalid <= 1'b0;

    // overfill the pool once so spawns overwrite the hinted slot
    for (int i = 0; i < 70; i++) pace_then_send(make_spawn());
    pace_then_send(make_cmd(ppu_pkg::CMD_RENDER, 0));
    pace_then_send(make_cmd(ppu_pkg::CMD_TICK, 31'($urandom_range(0, 1 << 16))));
    pace_then_send(make_cmd(ppu_pkg::CMD_RENDER, 0));

    // mostly spawn bursts, short ticks and renders; some clears and wild steps
    while (n_sent < 430) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 4)) pace_then_send(make_spawn());
      end else if (pick < 70) begin
        pace_then_send(make_cmd(ppu_pkg::CMD_TICK, 31'($urandom_range(0, 3 << 16))));
      end else if (pick < 75) begin
        pace_then_send(make_cmd(ppu_pkg::CMD_TICK, 31'($urandom)));
      end else if (pick < 97) begin
        pace_then_send(make_cmd(ppu_pkg::CMD_RENDER, 0));
      end else begin
        pace_then_send(make_cmd(ppu_pkg::CMD_CLEAR, 0));
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give the block time to show stray results
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("Sent %0d commands; checked %0d draw records, %0d empty renders,",
             n_sent, n_draws, n_empty);
    $display("and %0d spawns into a full pool.", n_full_spawn);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
